/* hw/rtl/dstp_pkg.sv */
// Shared constants, types and register codes for the drop-shadow tile packer.
package dstp_pkg;

	// Band geometry (whole 8x8 tiles expected)
	localparam int BAND_WIDTH     = 256;
	localparam int BAND_HEIGHT    = 48;
	localparam int TILE_SIDE      = 8;
	localparam int TILE_SHIFT     = 3;
	localparam int TILE_BYTE_SHIFT = 5;
	localparam int TILES_PER_ROW  = BAND_WIDTH / TILE_SIDE;

	// Field and counter widths
	localparam int COL_W       = $clog2(BAND_WIDTH);
	localparam int ROW_W       = $clog2(BAND_HEIGHT);
	localparam int COLOUR_W    = 4;
	localparam int BYTE_W      = 2 * COLOUR_W;
	localparam int ADDR_W      = 13;
	localparam int ADDR_FULL_W = $clog2(BAND_WIDTH * BAND_HEIGHT / 2);
	localparam int ADDR_CALC_W = (ADDR_FULL_W > ADDR_W) ? ADDR_FULL_W : ADDR_W;
	localparam int CFG_IDX_W   = 1;

	typedef logic [COLOUR_W-1:0] colour_t;

	localparam colour_t INK_RESET    = colour_t'(15);
	localparam colour_t SHADOW_RESET = colour_t'(14);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INK_COLOUR    = CFG_IDX_W'(0),
		REG_SHADOW_COLOUR = CFG_IDX_W'(1)
	} cfg_reg_t;

	// Position of the pixel being accepted, with derived flags and address
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              first_col;
		logic              first_row;
		logic              last_pixel;
		logic [ADDR_W-1:0] byte_addr;
	} pos_t;

endpackage

/* hw/rtl/dstp_line_store.sv */
// One-row line store: synchronous read-first RAM holding the previous row's ink bits.
module dstp_line_store (
	input  logic                      clk,
	input  logic                      en,
	input  logic [dstp_pkg::COL_W-1:0] addr,
	input  logic                      wr_bit,
	output logic                      rd_bit
);

	logic mem [dstp_pkg::BAND_WIDTH];
	logic rd_q;

	// Read the old bit above this column, then replace it with this row's bit
	always_ff @(posedge clk) begin
		if (en) begin
			rd_q      <= mem[addr];
			mem[addr] <= wr_bit;
		end
	end

	assign rd_bit = rd_q;

endmodule

/* hw/rtl/dstp_position.sv */
// Column and row counters with the tile-order byte address of the current pixel.
module dstp_position (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                frame_start,
	output dstp_pkg::pos_t      pos
);

	logic [dstp_pkg::COL_W-1:0]       col_q;
	logic [dstp_pkg::ROW_W-1:0]       row_q;
	logic [dstp_pkg::COL_W-1:0]       cur_col;
	logic [dstp_pkg::ROW_W-1:0]       cur_row;
	logic                             col_end;
	logic                             row_end;
	logic [dstp_pkg::ADDR_CALC_W-1:0] tile_idx;
	logic [dstp_pkg::ADDR_CALC_W-1:0] addr_full;

	// Band start overrides the stored position
	assign cur_col = frame_start ? '0 : col_q;
	assign cur_row = frame_start ? '0 : row_q;
	assign col_end = (cur_col == dstp_pkg::COL_W'(dstp_pkg::BAND_WIDTH - 1));
	assign row_end = (cur_row == dstp_pkg::ROW_W'(dstp_pkg::BAND_HEIGHT - 1));

	// Tile-order address: tile*32 + row_in_tile*4 + pair_in_row
	always_comb begin
		tile_idx = dstp_pkg::ADDR_CALC_W'(cur_row >> dstp_pkg::TILE_SHIFT)
			* dstp_pkg::ADDR_CALC_W'(dstp_pkg::TILES_PER_ROW)
			+ dstp_pkg::ADDR_CALC_W'(cur_col >> dstp_pkg::TILE_SHIFT);
		addr_full = (tile_idx << dstp_pkg::TILE_BYTE_SHIFT)
			| dstp_pkg::ADDR_CALC_W'({cur_row[2:0], cur_col[2:1]});
	end

	always_comb begin
		pos.col        = cur_col;
		pos.row        = cur_row;
		pos.first_col  = (cur_col == '0);
		pos.first_row  = (cur_row == '0);
		pos.last_pixel = col_end && row_end;
		pos.byte_addr  = addr_full[dstp_pkg::ADDR_W-1:0];
	end

	// Step in raster order, wrapping at row and band ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : cur_row + dstp_pkg::ROW_W'(1);
			end else begin
				col_q <= cur_col + dstp_pkg::COL_W'(1);
				row_q <= cur_row;
			end
		end
	end

	// An accepted band start leaves the counters at the second pixel of row zero
	a_band_start_pos: assert property (@(posedge clk) disable iff (!arst_n)
		advance && frame_start |=> col_q == dstp_pkg::COL_W'(1) && row_q == '0)
		else $error("position not restarted by band start");

endmodule

/* hw/rtl/drop_shadow_tile_packer_unit.sv */
// Top level: glyph pixels in, drop-shadowed 4bpp tile bytes out.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  pixel   | in_valid, in_ready, pixel_ink, frame_start | in
//  byte    | out_valid, out_ready, packed_byte,       | out
//          | byte_address, band_done                  |
//  config  | cfg_we, cfg_index, cfg_data              | in
//
// One pixel per cycle if in_ready; a byte is valid the cycle after an odd-column pixel.
// Each pixel reads and rewrites its line store entry in its accept cycle; the read-back
// bit serves as the above-left neighbor of the next pixel.
// Reset zeroes the counters and loads the colour resets; the line store is not cleared.
// Pixels stall only while a finished byte sits unread in the output register.
module drop_shadow_tile_packer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               pixel_ink,
	input  logic                               frame_start,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [dstp_pkg::BYTE_W-1:0]        packed_byte,
	output logic [dstp_pkg::ADDR_W-1:0]        byte_address,
	output logic                               band_done,
	input  logic                               cfg_we,
	input  logic [dstp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dstp_pkg::COLOUR_W-1:0]      cfg_data
);

	localparam logic [dstp_pkg::ADDR_W-1:0] LAST_ADDR =
		dstp_pkg::ADDR_W'(dstp_pkg::BAND_WIDTH * dstp_pkg::BAND_HEIGHT / 2 - 1);

	dstp_pkg::colour_t                ink_q;
	dstp_pkg::colour_t                shadow_q;
	dstp_pkg::colour_t                held_q;
	dstp_pkg::colour_t                colour;
	dstp_pkg::pos_t                   pos;
	logic                             accept;
	logic                             above_left;
	logic                             out_valid_q;
	logic [dstp_pkg::BYTE_W-1:0]      byte_q;
	logic [dstp_pkg::ADDR_W-1:0]      addr_q;
	logic                             done_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ink_q    <= dstp_pkg::INK_RESET;
			shadow_q <= dstp_pkg::SHADOW_RESET;
		end else if (cfg_we) begin
			case (dstp_pkg::cfg_reg_t'(cfg_index))
				dstp_pkg::REG_INK_COLOUR:    ink_q    <= cfg_data;
				dstp_pkg::REG_SHADOW_COLOUR: shadow_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dstp_position u_position (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.frame_start (frame_start),
		.pos         (pos)
	);

	dstp_line_store u_line_store (
		.clk    (clk),
		.en     (accept),
		.addr   (pos.col),
		.wr_bit (pixel_ink),
		.rd_bit (above_left)
	);

	// Colour pick: ink, else shadow from the above-left bit, else transparent
	always_comb begin
		if (pixel_ink)
			colour = ink_q;
		else if (!pos.first_col && !pos.first_row && above_left)
			colour = shadow_q;
		else
			colour = '0;
	end

	// Left pixel of each pair waits here
	always_ff @(posedge clk) begin
		if (accept && !pos.col[0])
			held_q <= colour;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && pos.col[0]) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pos.col[0]) begin
			byte_q <= {colour, held_q};
			addr_q <= pos.byte_addr;
			done_q <= pos.last_pixel;
		end
	end

	assign out_valid    = out_valid_q;
	assign packed_byte  = byte_q;
	assign byte_address = addr_q;
	assign band_done    = done_q;

	// Full output register holds off new pixels
	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !in_ready)
		else $error("pixel taken while byte stalled");

	// Band end always lands on the last byte of tile data
	a_done_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> addr_q == LAST_ADDR)
		else $error("band end at wrong address");

	// A new byte only follows an accepted odd-column pixel
	a_byte_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(accept && pos.col[0]))
		else $error("byte appeared without pixel pair");

endmodule

/* tb/sv/tb.sv */
// Testbench for the drop-shadow tile packer: random glyph bands checked against a predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ITEMS   = 1950;
	localparam int FULL_ROWS = 3;

	// One packed tile byte as the block should emit it
	typedef struct packed {
		logic [dstp_pkg::BYTE_W-1:0] data;
		logic [dstp_pkg::ADDR_W-1:0] addr;
		logic                        last;
	} tile_byte_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic                           pixel_ink = 1'b0;
	logic                           frame_start = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [dstp_pkg::BYTE_W-1:0]    packed_byte;
	logic [dstp_pkg::ADDR_W-1:0]    byte_address;
	logic                           band_done;
	logic                           cfg_we = 1'b0;
	logic [dstp_pkg::CFG_IDX_W-1:0] cfg_index = dstp_pkg::REG_INK_COLOUR;
	logic [dstp_pkg::COLOUR_W-1:0]  cfg_data = '0;

	// Shadow state of the block
	logic [dstp_pkg::BAND_WIDTH-1:0] line_bits = '0;
	logic                            diag_bit = 1'b0;
	logic [dstp_pkg::COL_W-1:0]      col_pos = '0;
	logic [dstp_pkg::ROW_W-1:0]      row_pos = '0;
	dstp_pkg::colour_t               held_nibble = '0;
	dstp_pkg::colour_t               ink_col = dstp_pkg::INK_RESET;
	dstp_pkg::colour_t               shadow_col = dstp_pkg::SHADOW_RESET;

	tile_byte_t tile_byte_q[$];
	tile_byte_t head_byte;

	logic no_idle = 1'b0;
	int   errors = 0;
	int   n_pixels = 0;
	int   n_bytes = 0;
	int   n_shadow = 0;
	int   n_band_end = 0;
	int   n_cfg = 0;

	drop_shadow_tile_packer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_ink    (pixel_ink),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packed_byte  (packed_byte),
		.byte_address (byte_address),
		.band_done    (band_done),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Byte sink: random back-pressure unless a no-idle stretch is on
	always @(posedge clk) begin
		out_ready <= no_idle || ($urandom_range(99) >= 26);
	end

	// Compare every byte taken at the next edge against the oldest expectation
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (tile_byte_q.size() == 0) begin
				$error("byte 0x%02h at address %0d with nothing expected", packed_byte,
					byte_address);
				errors++;
			end else begin
				head_byte = tile_byte_q.pop_front();
				n_bytes++;
				if (head_byte.last)
					n_band_end++;
				if (packed_byte !== head_byte.data) begin
					$error("packed_byte: expected 0x%02h, got 0x%02h", head_byte.data,
						packed_byte);
					errors++;
				end
				if (byte_address !== head_byte.addr) begin
					$error("byte_address: expected %0d, got %0d", head_byte.addr,
						byte_address);
					errors++;
				end
				if (band_done !== head_byte.last) begin
					$error("band_done: expected %0b, got %0b", head_byte.last, band_done);
					errors++;
				end
			end
		end
	end

	// Colour one accepted pixel and queue the tile byte it completes
	task automatic predict_tile_byte(input logic ink, input logic fs);
		dstp_pkg::colour_t shade;
		logic              up;
		int                tile_idx;
		int                offs;
		tile_byte_t        exp_b;
		if (fs) begin
			col_pos = '0;
			row_pos = '0;
			held_nibble = '0;
			diag_bit = 1'b0;
		end
		// bit above this column, taken before the line store is overwritten
		up = (row_pos != 0) ? line_bits[col_pos] : 1'b0;
		if (ink) begin
			shade = ink_col;
		end else if (col_pos != 0 && row_pos != 0 && diag_bit) begin
			shade = shadow_col;
			n_shadow++;
		end else begin
			shade = '0;
		end
		line_bits[col_pos] = ink;
		diag_bit = up;
		if (!col_pos[0]) begin
			held_nibble = shade;
		end else begin
			tile_idx = (int'(row_pos) / dstp_pkg::TILE_SIDE) * dstp_pkg::TILES_PER_ROW
				+ int'(col_pos) / dstp_pkg::TILE_SIDE;
			offs = (tile_idx << dstp_pkg::TILE_BYTE_SHIFT)
				+ (int'(row_pos) % dstp_pkg::TILE_SIDE) * (dstp_pkg::TILE_SIDE / 2)
				+ (int'(col_pos) % dstp_pkg::TILE_SIDE) / 2;
			exp_b.data = {shade, held_nibble};
			exp_b.addr = offs[dstp_pkg::ADDR_W-1:0];
			exp_b.last = (col_pos == dstp_pkg::COL_W'(dstp_pkg::BAND_WIDTH - 1)) &&
				(row_pos == dstp_pkg::ROW_W'(dstp_pkg::BAND_HEIGHT - 1));
			tile_byte_q.push_back(exp_b);
		end
		// advance position; end of row drops the diagonal, end of band wraps
		if (col_pos == dstp_pkg::COL_W'(dstp_pkg::BAND_WIDTH - 1)) begin
			col_pos = '0;
			diag_bit = 1'b0;
			row_pos = (row_pos == dstp_pkg::ROW_W'(dstp_pkg::BAND_HEIGHT - 1)) ? '0
				: row_pos + dstp_pkg::ROW_W'(1);
		end else begin
			col_pos = col_pos + dstp_pkg::COL_W'(1);
		end
	endtask

	// Present one pixel request, with a random lead-in gap, and wait for it to be taken
	task automatic send_pixel(input logic ink, input logic fs);
		int   gap;
		logic took;
		gap = 0;
		if (!no_idle)
			while (gap < 30 && $urandom_range(99) < 26)
				gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_ink <= ink;
		frame_start <= fs;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		predict_tile_byte(ink, fs);
		n_pixels++;
	endtask

	// Hold off requests until every queued byte has come back, then let the block settle
	task automatic wait_bytes_drained();
		int spins;
		spins = 0;
		in_valid <= 1'b0;
		while (tile_byte_q.size() != 0 && spins < 5000) begin
			@(posedge clk);
			spins++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_colour(input dstp_pkg::cfg_reg_t which,
		input dstp_pkg::colour_t value);
		wait_bytes_drained();
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (which)
			dstp_pkg::REG_INK_COLOUR: ink_col = value;
			dstp_pkg::REG_SHADOW_COLOUR: shadow_col = value;
			default: ;
		endcase
		n_cfg++;
	endtask

	// Row zero: every pair combination, a tile boundary and band restarts mid-row
	task automatic test_row_zero_pairs();
		int i;
		send_pixel(1'b1, 1'b1);
		send_pixel(1'b0, 1'b0);
		send_pixel(1'b0, 1'b0);
		send_pixel(1'b1, 1'b0);
		send_pixel(1'b1, 1'b0);
		send_pixel(1'b1, 1'b0);
		send_pixel(1'b0, 1'b0);
		send_pixel(1'b0, 1'b0);
		for (i = 0; i < 4; i++)
			send_pixel(i[0], 1'b0);
		// restart while a left nibble is held: it must be dropped
		send_pixel(1'b1, 1'b0);
		send_pixel(1'b0, 1'b1);
		send_pixel(1'b0, 1'b0);
		send_pixel(1'b1, 1'b0);
		send_pixel(1'b1, 1'b0);
		// restart on a left pixel carrying ink
		send_pixel(1'b1, 1'b0);
		send_pixel(1'b1, 1'b1);
		send_pixel(1'b1, 1'b0);
	endtask

	// Colour registers at their extremes and equal to each other
	task automatic test_colour_registers();
		dstp_pkg::colour_t inks[4];
		dstp_pkg::colour_t shadows[4];
		int                k;
		inks = '{4'h0, 4'hF, 4'h5, dstp_pkg::INK_RESET};
		shadows = '{4'hF, 4'h0, 4'h5, dstp_pkg::SHADOW_RESET};
		for (k = 0; k < 4; k++) begin
			set_colour(dstp_pkg::REG_INK_COLOUR, inks[k]);
			set_colour(dstp_pkg::REG_SHADOW_COLOUR, shadows[k]);
			send_pixel(1'b1, 1'b1);
			send_pixel(1'b0, 1'b0);
			send_pixel(1'b0, 1'b0);
			send_pixel(1'b1, 1'b0);
		end
	endtask

	// Several whole rows from a band start, the first two with no idling on either side
	task automatic test_full_rows();
		int i;
		no_idle <= 1'b1;
		for (i = 0; i < FULL_ROWS * dstp_pkg::BAND_WIDTH; i++) begin
			if (i == 2 * dstp_pkg::BAND_WIDTH)
				no_idle <= 1'b0;
			send_pixel($urandom_range(99) < 30, i == 0);
		end
	endtask

	// Random bands of a few rows, short fragments, stray restarts and colour changes
	task automatic test_random_bands();
		int   kind;
		int   len;
		int   density;
		int   i;
		logic restart;
		while (n_pixels < N_ITEMS) begin
			kind = $urandom_range(99);
			if (kind < 10) begin
				set_colour(dstp_pkg::cfg_reg_t'($urandom_range(1)),
					($urandom_range(3) == 0) ? ($urandom_range(1) ? 4'hF : 4'h0)
						: dstp_pkg::colour_t'($urandom_range(15)));
			end else begin
				len = (kind < 80) ? $urandom_range(260, 520) : $urandom_range(1, 40);
				if (len > N_ITEMS - n_pixels)
					len = N_ITEMS - n_pixels;
				density = $urandom_range(5, 70);
				restart = ($urandom_range(9) != 0);
				for (i = 0; i < len; i++)
					send_pixel($urandom_range(99) < density,
						(i == 0 && restart) || ($urandom_range(999) < 3));
			end
		end
	endtask

	initial begin
		#5_000_000;
		$display("FAIL drop_shadow_tile_packer_unit");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		test_row_zero_pairs();
		test_colour_registers();
		test_full_rows();
		test_random_bands();
		wait_bytes_drained();

		if (tile_byte_q.size() != 0) begin
			$error("%0d expected bytes never arrived", tile_byte_q.size());
			errors++;
		end
		$display("Run: %0d pixels in, %0d tile bytes compared, %0d band-end bytes.",
			n_pixels, n_bytes, n_band_end);
		$display("Run: %0d shadow pixels, %0d colour register writes, %0d errors.",
			n_shadow, n_cfg, errors);
		if (errors == 0)
			$display("PASS drop_shadow_tile_packer_unit");
		else
			$display("FAIL drop_shadow_tile_packer_unit");
		$finish;
	end

endmodule
